// ----- design/tile_map_rect_collision_core_assert.svh -----
// Assertion macros used by the collision core checker.
`ifndef TILE_MAP_RECT_COLLISION_CORE_ASSERT_SVH
`define TILE_MAP_RECT_COLLISION_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TMRC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tmrc assertion failed");

// next-cycle implication, disabled in reset
`define TMRC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tmrc assertion failed");

`endif

// ----- design/tmrc_pkg.sv -----
// Shared types, codes and helpers of the tile map collision core.
`default_nettype none
package tmrc_pkg;

  localparam int DEF_MAX_MAP_COLS  = 1024;
  localparam int DEF_MAX_MAP_ROWS  = 32;
  localparam int DEF_SCREEN_WIDTH  = 384;
  localparam int DEF_SCREEN_HEIGHT = 256;
  localparam int DEF_HUD_TILE_ROWS = 2;

  // widths sized for the largest supported map
  localparam int COL_IW = 12;
  localparam int ROW_IW = 7;
  localparam int MC_W   = 13;
  localparam int MR_W   = 8;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_SCROLL  = 2'd1;
  localparam logic [1:0] REQ_OVERLAP = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TILE = 2'd1;
  localparam logic [1:0] KIND_EDGE = 2'd2;

  localparam logic CFG_MAP_COLS = 1'b0;
  localparam logic CFG_MAP_ROWS = 1'b1;

  // highest field first, so {tuser, tdata} maps straight onto it
  typedef struct packed {
    logic [1:0]         req_type;
    logic [12:0]        scroll_pos;
    logic signed [10:0] rect_max_y;
    logic signed [13:0] rect_max_x;
    logic signed [10:0] rect_min_y;
    logic signed [13:0] rect_min_x;
    logic               tile_solid;
    logic [4:0]         tile_row;
    logic [9:0]         tile_col;
  } query_t;

  typedef struct packed {
    logic              walk;
    logic              rows_go;
    logic              up_en;
    logic              dn_en;
    logic              l_en;
    logic              r_en;
    logic [COL_IW-1:0] c0;
    logic [COL_IW-1:0] c1;
    logic [ROW_IW-1:0] r0;
    logic [ROW_IW-1:0] r1;
    logic [13:0]       cx_l;
    logic [13:0]       cx_r;
    logic [10:0]       cy_up;
    logic [10:0]       cy_dn;
    logic [3:0]        edge_mask;
    logic [13:0]       edge_cx;
    logic [10:0]       edge_cy;
  } plan_t;

  // signed divide by tile size, truncating toward zero
  function automatic logic signed [15:0] div8(input logic signed [15:0] v);
    logic signed [15:0] b;
    b = v + (v[15] ? 16'sd7 : 16'sd0);
    return b >>> 3;
  endfunction

endpackage
`default_nettype wire

// ----- design/tmrc_plan.sv -----
// Query setup: scroll clamp, tile bounds, walk plan and screen edge result.
`default_nettype none
module tmrc_plan #(
  parameter int SCREEN_WIDTH  = tmrc_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tmrc_pkg::DEF_SCREEN_HEIGHT,
  parameter int HUD_TILE_ROWS = tmrc_pkg::DEF_HUD_TILE_ROWS
) (
  input  tmrc_pkg::query_t                query_i,
  input  logic [tmrc_pkg::MC_W-1:0]       map_cols_i,
  input  logic [tmrc_pkg::MR_W-1:0]       map_rows_i,
  output tmrc_pkg::plan_t                 plan_o
);

  localparam int HUD_LINE = SCREEN_HEIGHT - HUD_TILE_ROWS * 8;

  logic signed [17:0] lim;
  logic [17:0]        lim_c;
  logic [12:0]        scr;
  logic               scroll_mode;
  logic               ovl_mode;
  logic signed [15:0] ofs, x0e, x1e, y0e, y1e;
  logic signed [15:0] left, right, up, down;
  logic signed [15:0] mc, mr;
  logic signed [15:0] up_c, dn_c, l_c, r_c;
  logic signed [15:0] up_c1, l_c1;

  always_comb begin
    scroll_mode = (query_i.req_type == tmrc_pkg::REQ_SCROLL);
    ovl_mode    = (query_i.req_type == tmrc_pkg::REQ_OVERLAP);
    lim   = $signed({2'b00, map_cols_i, 3'b000}) - $signed(18'(SCREEN_WIDTH));
    lim_c = lim[17] ? 18'd0 : lim;
    scr   = ({5'b00000, query_i.scroll_pos} < lim_c) ? query_i.scroll_pos : lim_c[12:0];
    ofs   = scroll_mode ? $signed({3'b000, scr}) : 16'sd0;
    x0e   = 16'(query_i.rect_min_x);
    x1e   = 16'(query_i.rect_max_x);
    y0e   = 16'(query_i.rect_min_y);
    y1e   = 16'(query_i.rect_max_y);
    left  = tmrc_pkg::div8(x0e + ofs);
    right = tmrc_pkg::div8(x1e + ofs);
    up    = tmrc_pkg::div8(y0e);
    down  = tmrc_pkg::div8(y1e);
    mc    = $signed({3'b000, map_cols_i});
    mr    = $signed({8'h00, map_rows_i});
    up_c  = up[15] ? 16'sd0 : up;
    l_c   = left[15] ? 16'sd0 : left;
    dn_c  = (down > mr - 16'sd1) ? mr - 16'sd1 : down;
    r_c   = (right > mc - 16'sd1) ? mc - 16'sd1 : right;
    up_c1 = up_c + 16'sd1;
    l_c1  = l_c + 16'sd1;

    plan_o.walk    = (scroll_mode || ovl_mode) && (up < mr) && (left < mc) &&
                     !right[15] && !down[15];
    plan_o.rows_go = (l_c <= r_c);
    plan_o.up_en   = ovl_mode || !up[15];
    plan_o.dn_en   = ovl_mode || (down < mr);
    plan_o.l_en    = ovl_mode || !left[15];
    plan_o.r_en    = ovl_mode || (right < mc);
    plan_o.c0      = l_c[tmrc_pkg::COL_IW-1:0];
    plan_o.c1      = r_c[tmrc_pkg::COL_IW-1:0];
    plan_o.r0      = up_c[tmrc_pkg::ROW_IW-1:0];
    plan_o.r1      = dn_c[tmrc_pkg::ROW_IW-1:0];
    plan_o.cx_l    = {l_c1[10:0], 3'b000};
    plan_o.cx_r    = {r_c[10:0], 3'b000};
    plan_o.cy_up   = {up_c1[7:0], 3'b000};
    plan_o.cy_dn   = {dn_c[7:0], 3'b000};

    plan_o.edge_mask = {x1e >= $signed(16'(SCREEN_WIDTH)), x0e[15],
                        y1e >= $signed(16'(HUD_LINE)), y0e[15]};
    plan_o.edge_cx = x0e[15] ? 14'd0 :
                     (plan_o.edge_mask[3] ? 14'(SCREEN_WIDTH) : 14'd0);
    plan_o.edge_cy = y0e[15] ? 11'd0 :
                     (plan_o.edge_mask[1] ? 11'(HUD_LINE) : 11'd0);
  end

endmodule
`default_nettype wire

// ----- design/tile_map_rect_collision_core.sv -----
// Top level of the tile map rectangle collision core.
// Usage:
//  - s_axis carries one request word; tuser selects write tile, scrolled
//    collision or plain overlap. m_axis returns exactly one result word per
//    request. cfg writes map_cols (index 0) or map_rows (index 1); the user
//    must write them only while idle, which the core does not enforce.
//  - The map is a column-organized memory, one word of MAX_MAP_ROWS bits per
//    tile column, one read and one write port, registered read data.
//  - A write reads the tile column, writes it back modified if in range, then
//    posts the result. A query reads each tile column spanned by the clipped
//    rectangle if a top or bottom row is checked, then its left and right
//    columns, between setup and drain; off-map or unknown requests skip them.
//  - One request is processed at a time; the next is taken once the current
//    result sits in the output register, even while m_axis is stalled.
//  - A stalled result holds; the core then waits before posting the next.
//  - After reset the map is swept to zero, one column per cycle, over all
//    MAX_MAP_COLS columns; s_axis_tready stays low meanwhile. cfg is always
//    ready. Map size registers reset to 1024 x 32, clipped to the maximum.
`default_nettype none
module tile_map_rect_collision_core #(
  parameter int MAX_MAP_COLS  = tmrc_pkg::DEF_MAX_MAP_COLS,
  parameter int MAX_MAP_ROWS  = tmrc_pkg::DEF_MAX_MAP_ROWS,
  parameter int SCREEN_WIDTH  = tmrc_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tmrc_pkg::DEF_SCREEN_HEIGHT,
  parameter int HUD_TILE_ROWS = tmrc_pkg::DEF_HUD_TILE_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tile_col[9:0] tile_row[14:10] tile_solid[15] rect_min_x[29:16]
  // rect_min_y[40:30] rect_max_x[54:41] rect_max_y[65:55] scroll_pos[78:66]
  input  logic [79:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit_mask[3:0] contact_x[17:4] contact_y[28:18] overlap[29]
  output logic [31:0] m_axis_tdata,
  // hit_kind[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int CAW      = $clog2(MAX_MAP_COLS);
  localparam int RAW      = $clog2(MAX_MAP_ROWS);
  localparam int RST_COLS = (MAX_MAP_COLS < 1024) ? MAX_MAP_COLS : 1024;
  localparam int RST_ROWS = (MAX_MAP_ROWS < 32) ? MAX_MAP_ROWS : 32;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_SETUP  = 4'd2;
  localparam logic [3:0] ST_WR_RD  = 4'd3;
  localparam logic [3:0] ST_WR_MOD = 4'd4;
  localparam logic [3:0] ST_ROWS   = 4'd5;
  localparam logic [3:0] ST_COL_L  = 4'd6;
  localparam logic [3:0] ST_COL_R  = 4'd7;
  localparam logic [3:0] ST_DRAIN  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [MAX_MAP_ROWS-1:0] mem_q [MAX_MAP_COLS];
  logic [MAX_MAP_ROWS-1:0] rd_q;
  logic                    mem_we;
  logic [CAW-1:0]          mem_waddr, mem_raddr;
  logic [MAX_MAP_ROWS-1:0] mem_wdata;

  logic [3:0]              state_q, state_d;
  logic [CAW-1:0]          col_q, col_d;
  tmrc_pkg::query_t        query_q, s_query;
  tmrc_pkg::plan_t         plan_q, plan;
  logic [tmrc_pkg::MC_W-1:0] map_cols_q;
  logic [tmrc_pkg::MR_W-1:0] map_rows_q;
  logic [tmrc_pkg::MC_W-1:0] cols_v;
  logic [tmrc_pkg::MR_W-1:0] rows_v;
  logic                    tag_row_q, tag_l_q, tag_r_q;
  logic                    tag_row_d, tag_l_d, tag_r_d;
  logic                    hu_q, hd_q, hl_q, hr_q;
  logic [MAX_MAP_ROWS-1:0] rng;
  logic                    wr_ok;
  logic                    out_vld_q;
  logic [31:0]             out_data_q, res_data;
  logic [1:0]              out_user_q, res_user;
  logic [3:0]              tmask;
  logic [13:0]             res_cx;
  logic [10:0]             res_cy;
  logic                    s_fire, out_free;

  assign s_query = {s_axis_tuser, s_axis_tdata[78:0]} ;

  tmrc_plan #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .HUD_TILE_ROWS(HUD_TILE_ROWS)
  ) u_plan (
    .query_i   (query_q),
    .map_cols_i(map_cols_q),
    .map_rows_i(map_rows_q),
    .plan_o    (plan)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // map size registers, saturated to the supported range
  always_comb begin
    cols_v = {2'b00, cfg_data_i};
    rows_v = {2'b00, cfg_data_i[5:0]};
    if (cols_v == '0) begin
      cols_v = tmrc_pkg::MC_W'(1);
    end else if (cols_v > tmrc_pkg::MC_W'(MAX_MAP_COLS)) begin
      cols_v = tmrc_pkg::MC_W'(MAX_MAP_COLS);
    end
    if (rows_v == '0) begin
      rows_v = tmrc_pkg::MR_W'(1);
    end else if (rows_v > tmrc_pkg::MR_W'(MAX_MAP_ROWS)) begin
      rows_v = tmrc_pkg::MR_W'(MAX_MAP_ROWS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cols_q <= tmrc_pkg::MC_W'(RST_COLS);
      map_rows_q <= tmrc_pkg::MR_W'(RST_ROWS);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tmrc_pkg::CFG_MAP_COLS) begin
        map_cols_q <= cols_v;
      end else begin
        map_rows_q <= rows_v;
      end
    end
  end

  // tile map memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign wr_ok = ({3'b000, query_q.tile_col} < 13'(MAX_MAP_COLS)) &&
                 ({3'b000, query_q.tile_row} < 8'(MAX_MAP_ROWS));

  always_comb begin
    for (int i = 0; i < MAX_MAP_ROWS; i++) begin
      rng[i] = (tmrc_pkg::ROW_IW'(i) >= plan_q.r0) && (tmrc_pkg::ROW_IW'(i) <= plan_q.r1);
    end
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    mem_we    = 1'b0;
    mem_waddr = col_q;
    mem_wdata = '0;
    mem_raddr = col_q;
    tag_row_d = 1'b0;
    tag_l_d   = 1'b0;
    tag_r_d   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        col_d  = col_q + 1'b1;
        if (col_q == CAW'(MAX_MAP_COLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == tmrc_pkg::REQ_WRITE) begin
            state_d = ST_WR_RD;
          end else if (s_axis_tuser == tmrc_pkg::REQ_SCROLL ||
                       s_axis_tuser == tmrc_pkg::REQ_OVERLAP) begin
            state_d = ST_SETUP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WR_RD: begin
        mem_raddr = CAW'(query_q.tile_col);
        state_d   = wr_ok ? ST_WR_MOD : ST_DONE;
      end
      ST_WR_MOD: begin
        mem_we    = 1'b1;
        mem_waddr = CAW'(query_q.tile_col);
        mem_wdata = rd_q;
        mem_wdata[RAW'(query_q.tile_row)] = query_q.tile_solid;
        state_d   = ST_DONE;
      end
      ST_SETUP: begin
        col_d = CAW'(plan.c0);
        if (!plan.walk) begin
          state_d = ST_DONE;
        end else if (plan.rows_go && (plan.up_en || plan.dn_en)) begin
          state_d = ST_ROWS;
        end else begin
          state_d = ST_COL_L;
        end
      end
      ST_ROWS: begin
        tag_row_d = 1'b1;
        col_d     = col_q + 1'b1;
        if (col_q == CAW'(plan_q.c1)) begin
          state_d = ST_COL_L;
        end
      end
      ST_COL_L: begin
        mem_raddr = CAW'(plan_q.c0);
        tag_l_d   = plan_q.l_en;
        state_d   = ST_COL_R;
      end
      ST_COL_R: begin
        mem_raddr = CAW'(plan_q.c1);
        tag_r_d   = plan_q.r_en;
        state_d   = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      col_q     <= '0;
      tag_row_q <= 1'b0;
      tag_l_q   <= 1'b0;
      tag_r_q   <= 1'b0;
      hu_q      <= 1'b0;
      hd_q      <= 1'b0;
      hl_q      <= 1'b0;
      hr_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      tag_row_q <= tag_row_d;
      tag_l_q   <= tag_l_d;
      tag_r_q   <= tag_r_d;
      if (state_q == ST_SETUP) begin
        hu_q <= 1'b0;
        hd_q <= 1'b0;
        hl_q <= 1'b0;
        hr_q <= 1'b0;
      end else begin
        if (tag_row_q) begin
          hu_q <= hu_q | (plan_q.up_en & rd_q[RAW'(plan_q.r0)]);
          hd_q <= hd_q | (plan_q.dn_en & rd_q[RAW'(plan_q.r1)]);
        end
        if (tag_l_q) begin
          hl_q <= hl_q | (|(rd_q & rng));
        end
        if (tag_r_q) begin
          hr_q <= hr_q | (|(rd_q & rng));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      query_q <= s_query;
    end
    if (state_q == ST_SETUP) begin
      plan_q <= plan;
    end
  end

  // result formation
  always_comb begin
    tmask    = {hr_q, hl_q, hd_q, hu_q};
    res_cx   = hr_q ? plan_q.cx_r : (hl_q ? plan_q.cx_l : 14'd0);
    res_cy   = hd_q ? plan_q.cy_dn : (hu_q ? plan_q.cy_up : 11'd0);
    res_data = '0;
    res_user = tmrc_pkg::KIND_NONE;
    case (query_q.req_type)
      tmrc_pkg::REQ_SCROLL: begin
        if (tmask != 4'd0) begin
          res_data = {3'b000, res_cy, res_cx, tmask};
          res_user = tmrc_pkg::KIND_TILE;
        end else if (plan_q.edge_mask != 4'd0) begin
          res_data = {3'b000, plan_q.edge_cy, plan_q.edge_cx, plan_q.edge_mask};
          res_user = tmrc_pkg::KIND_EDGE;
        end
      end
      tmrc_pkg::REQ_OVERLAP: begin
        res_data[29] = |tmask;
      end
      default: begin
        res_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= res_data;
      out_user_q <= res_user;
    end
  end

endmodule
`default_nettype wire

// ----- design/tmrc_checker.sv -----
// Port-level checker for the collision core, bound to the top level.
`default_nettype none
`include "tile_map_rect_collision_core_assert.svh"
module tmrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `TMRC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `TMRC_ASSERT_IMP(a_none_is_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == tmrc_pkg::KIND_NONE, m_axis_tdata[28:0] == 29'd0)
  `TMRC_ASSERT_IMP(a_kind_has_mask, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != tmrc_pkg::KIND_NONE, m_axis_tdata[3:0] != 4'd0 && !m_axis_tdata[29])
  `TMRC_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:30] == 2'b00 && m_axis_tuser != 2'd3)

endmodule

bind tile_map_rect_collision_core tmrc_checker u_tmrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

// ----- bench/tb_tile_map_rect_collision_checker.sv -----
// Checker for the tile map collision core: watches all channels, predicts results, compares.
module tb_tile_map_rect_collision_checker
  import tmrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [79:0] s_data_i,
  input  logic [1:0]  s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,
  input  logic [1:0]  m_user_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE = 8;
  localparam int EDGE_Y = DEF_SCREEN_HEIGHT - DEF_HUD_TILE_ROWS * TILE;

  typedef struct packed {
    logic [3:0]  hit_mask;
    logic [13:0] contact_x;
    logic [10:0] contact_y;
    logic [1:0]  hit_kind;
    logic        overlap;
  } outcome_t;

  bit       occ [0:DEF_MAX_MAP_ROWS-1][0:DEF_MAX_MAP_COLS-1];
  int       map_cols;
  int       map_rows;
  outcome_t outcomes_q[$];

  assign pending_o = outcomes_q.size();

  function automatic bit tile_at(int r, int c);
    if (r < 0 || c < 0 || r >= DEF_MAX_MAP_ROWS || c >= DEF_MAX_MAP_COLS) return 0;
    return occ[r][c];
  endfunction

  function automatic bit row_solid(int r, int c0, int c1);
    bit h;
    h = 0;
    for (int c = c0; c <= c1; c++) if (tile_at(r, c)) h = 1;
    return h;
  endfunction

  function automatic bit col_solid(int c, int r0, int r1);
    bit h;
    h = 0;
    for (int r = r0; r <= r1; r++) if (tile_at(r, c)) h = 1;
    return h;
  endfunction

  function automatic outcome_t scrolled_hit(int x0, int y0, int x1, int y1, int req_scroll);
    outcome_t o;
    int lim, scr, up, dn, lf, rt, c0, c1, r0, r1, cx, cy;
    logic [3:0] m;
    o = '0;
    m = '0;
    cx = 0;
    cy = 0;
    lim = map_cols * TILE - DEF_SCREEN_WIDTH;
    scr = (lim < 0) ? 0 : lim;
    if (req_scroll < scr) scr = req_scroll;
    up = y0 / TILE;
    dn = y1 / TILE;
    lf = (scr + x0) / TILE;
    rt = (scr + x1) / TILE;
    if (up < map_rows && lf < map_cols && rt >= 0 && dn >= 0) begin
      c0 = (lf < 0) ? 0 : lf;
      c1 = (rt > map_cols - 1) ? map_cols - 1 : rt;
      r0 = (up < 0) ? 0 : up;
      r1 = (dn > map_rows - 1) ? map_rows - 1 : dn;
      if (up >= 0 && row_solid(up, c0, c1)) begin
        m[0] = 1;
        cy = (up + 1) * TILE;
      end
      if (dn < map_rows && row_solid(dn, c0, c1)) begin
        m[1] = 1;
        cy = dn * TILE;
      end
      if (lf >= 0 && col_solid(lf, r0, r1)) begin
        m[2] = 1;
        cx = (lf + 1) * TILE;
      end
      if (rt < map_cols && col_solid(rt, r0, r1)) begin
        m[3] = 1;
        cx = rt * TILE;
      end
      if (m != 0) begin
        o.hit_mask = m;
        o.contact_x = cx[13:0];
        o.contact_y = cy[10:0];
        o.hit_kind = KIND_TILE;
        return o;
      end
    end
    if (y1 >= EDGE_Y) begin
      m[1] = 1;
      cy = EDGE_Y;
    end
    if (y0 < 0) begin
      m[0] = 1;
      cy = 0;
    end
    if (x1 >= DEF_SCREEN_WIDTH) begin
      m[3] = 1;
      cx = DEF_SCREEN_WIDTH;
    end
    if (x0 < 0) begin
      m[2] = 1;
      cx = 0;
    end
    if (m != 0) begin
      o.hit_mask = m;
      o.contact_x = cx[13:0];
      o.contact_y = cy[10:0];
      o.hit_kind = KIND_EDGE;
    end
    return o;
  endfunction

  function automatic bit border_overlap(int x0, int y0, int x1, int y1);
    int up, dn, lf, rt;
    up = y0 / TILE;
    if (up < 0) up = 0;
    dn = y1 / TILE;
    if (dn > map_rows - 1) dn = map_rows - 1;
    lf = x0 / TILE;
    if (lf < 0) lf = 0;
    rt = x1 / TILE;
    if (rt > map_cols - 1) rt = map_cols - 1;
    if (up >= map_rows || lf >= map_cols || rt < 0 || dn < 0) return 0;
    return row_solid(up, lf, rt) || row_solid(dn, lf, rt) ||
           col_solid(lf, up, dn) || col_solid(rt, up, dn);
  endfunction

  function automatic outcome_t serve_request(logic [1:0] req, logic [79:0] d);
    outcome_t o;
    int x0, y0, x1, y1;
    o = '0;
    x0 = int'($signed(d[29:16]));
    y0 = int'($signed(d[40:30]));
    x1 = int'($signed(d[54:41]));
    y1 = int'($signed(d[65:55]));
    case (req)
      REQ_WRITE: occ[d[14:10]][d[9:0]] = d[15];
      REQ_SCROLL: o = scrolled_hit(x0, y0, x1, y1, int'(d[78:66]));
      REQ_OVERLAP: o.overlap = border_overlap(x0, y0, x1, y1);
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e, a;
    int v;
    if (!rst_ni) begin
      foreach (occ[r, c]) occ[r][c] = 0;
      map_cols = DEF_MAX_MAP_COLS;
      map_rows = DEF_MAX_MAP_ROWS;
      outcomes_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_MAP_COLS) begin
          v = int'(cfg_data_i);
          map_cols = (v < 1) ? 1 : (v > DEF_MAX_MAP_COLS) ? DEF_MAX_MAP_COLS : v;
        end else begin
          v = int'(cfg_data_i[5:0]);
          map_rows = (v < 1) ? 1 : (v > DEF_MAX_MAP_ROWS) ? DEF_MAX_MAP_ROWS : v;
        end
      end
      if (s_valid_i && s_ready_i) outcomes_q.push_back(serve_request(s_user_i, s_data_i));
      if (m_valid_i && m_ready_i) begin
        a.hit_mask = m_data_i[3:0];
        a.contact_x = m_data_i[17:4];
        a.contact_y = m_data_i[28:18];
        a.overlap = m_data_i[29];
        a.hit_kind = m_user_i;
        if (outcomes_q.size() == 0) begin
          $error("result word with nothing expected");
          errors_o++;
        end else begin
          e = outcomes_q.pop_front();
          if (a.hit_mask != e.hit_mask) begin
            $error("hit_mask exp %0d got %0d", e.hit_mask, a.hit_mask);
            errors_o++;
          end
          if (a.contact_x != e.contact_x) begin
            $error("contact_x exp %0d got %0d", e.contact_x, a.contact_x);
            errors_o++;
          end
          if (a.contact_y != e.contact_y) begin
            $error("contact_y exp %0d got %0d", e.contact_y, a.contact_y);
            errors_o++;
          end
          if (a.hit_kind != e.hit_kind) begin
            $error("hit_kind exp %0d got %0d", e.hit_kind, a.hit_kind);
            errors_o++;
          end
          if (a.overlap != e.overlap) begin
            $error("overlap exp %0d got %0d", e.overlap, a.overlap);
            errors_o++;
          end
        end
      end
    end
  end
endmodule

// ----- bench/tb_tile_map_rect_collision_core.sv -----
// Testbench top for the tile map collision core: stimulus, flow control and verdict.
module tb_tile_map_rect_collision_core;
  import tmrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = REQ_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_MAP_COLS;
  logic [10:0] cfg_data_i = '0;

  int errors, pending;
  int words_sent = 0;
  bit calm = 0;
  bit hold_done = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  tile_map_rect_collision_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  tb_tile_map_rect_collision_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [79:0] pack(int col, int row, int solid, int x0, int y0,
                                       int x1, int y1, int scroll);
    logic [79:0] d;
    d = '0;
    d[9:0] = col[9:0];
    d[14:10] = row[4:0];
    d[15] = solid[0];
    d[29:16] = x0[13:0];
    d[40:30] = y0[10:0];
    d[54:41] = x1[13:0];
    d[65:55] = y1[10:0];
    d[78:66] = scroll[12:0];
    return d;
  endfunction

  task automatic send_word(logic [1:0] req, logic [79:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= req;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic write_reg(logic idx, int v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v[10:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_word();
    int p, x0, y0, w, h, scr;
    logic [1:0] req;
    p = $urandom_range(0, 99);
    if (p < 2) begin
      send_word(2'd3, {$urandom, $urandom, $urandom});
      return;
    end
    if (p < 32) begin
      send_word(REQ_WRITE, pack(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                 : $urandom_range(0, 99), $urandom_range(0, 31),
                                 $urandom_range(0, 2) != 0, $urandom, $urandom,
                                 $urandom, $urandom, $urandom));
      return;
    end
    req = (p < 70) ? REQ_SCROLL : REQ_OVERLAP;
    scr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 300);
    if ($urandom_range(0, 32) == 0) begin
      send_word(req, pack($urandom, $urandom, $urandom,
                          $urandom_range(0, 9215) - 1024, $urandom_range(0, 2047) - 1024,
                          $urandom_range(0, 9215) - 1024, $urandom_range(0, 2047) - 1024,
                          scr));
      return;
    end
    x0 = $urandom_range(0, 560) - 80;
    y0 = $urandom_range(0, 320) - 40;
    w = $urandom_range(0, 24);
    h = $urandom_range(0, 24);
    if ($urandom_range(0, 24) == 0) begin
      w = -w;
      h = -h;
    end
    send_word(req, pack($urandom, $urandom, $urandom, x0, y0, x0 + w, y0 + h, scr));
  endtask

  task automatic directed_words();
    send_word(REQ_WRITE, pack(0, 0, 1, 0, 0, 0, 0, 0));
    send_word(REQ_WRITE, pack(1023, 31, 1, -1, -1, -1, -1, 8191));
    send_word(REQ_WRITE, pack(5, 3, 1, 0, 0, 0, 0, 0));
    send_word(REQ_WRITE, pack(6, 4, 0, 0, 0, 0, 0, 0));
    send_word(REQ_WRITE, pack(60, 10, 1, 0, 0, 0, 0, 0));
    send_word(2'd3, {16'h0, {64{1'b1}}});
    send_word(REQ_SCROLL, pack(0, 0, 0, 0, 0, 15, 15, 0));
    send_word(REQ_SCROLL, pack(0, 0, 0, 36, 20, 48, 36, 0));
    send_word(REQ_SCROLL, pack(0, 0, 0, -1024, -1024, 8191, 1023, 8191));
    send_word(REQ_SCROLL, pack(0, 0, 0, -7, -7, -1, -1, 0));
    send_word(REQ_SCROLL, pack(0, 0, 0, 100, 100, 120, 240, 0));
    send_word(REQ_SCROLL, pack(0, 0, 0, 100, 100, 384, 120, 0));
    send_word(REQ_SCROLL, pack(0, 0, 0, 60, 60, 40, 40, 0));
    send_word(REQ_SCROLL, pack(0, 0, 0, 400, 70, 420, 90, 8191));
    send_word(REQ_SCROLL, pack(0, 0, 0, 8191, 1023, -1024, -1024, 0));
    send_word(REQ_OVERLAP, pack(0, 0, 0, 0, 0, 7, 7, 0));
    send_word(REQ_OVERLAP, pack(0, 0, 0, -1024, -1024, 8191, 1023, 0));
    send_word(REQ_OVERLAP, pack(0, 0, 0, 8184, 248, 8191, 255, 0));
    send_word(REQ_OVERLAP, pack(0, 0, 0, 40, 24, 47, 31, 0));
    send_word(REQ_OVERLAP, pack(0, 0, 0, 60, 60, 30, 30, 0));
    send_word(REQ_WRITE, pack(1023, 31, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    int col_set [7] = '{1024, 100, 48, 1, 0, 2047, 30};
    int row_set [7] = '{32, 20, 32, 1, 0, 63, 8};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_MAP_COLS, col_set[ph]);
      write_reg(CFG_MAP_ROWS, row_set[ph]);
      calm = (ph == 2);
      if (ph == 0 || ph == 3) directed_words();
      repeat (210) random_word();
      drain();
    end
    if (errors == 0) $display("tb_tile_map_rect_collision_core: clean");
    else $display("tb_tile_map_rect_collision_core: errors");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the core
  initial begin
    int p;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      p = $urandom_range(0, 99);
      if (!hold_done && words_sent >= 300) begin
        m_axis_tready <= 0;
        hold_done = 1;
        repeat (400) @(posedge clk_i);
      end else if (calm || p < 70) begin
        m_axis_tready <= 1;
      end else if (p < 97) begin
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_tile_map_rect_collision_core: errors");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/tmrc_pkg.sv
design/tmrc_plan.sv
design/tile_map_rect_collision_core.sv
design/tmrc_checker.sv
bench/tb_tile_map_rect_collision_checker.sv
bench/tb_tile_map_rect_collision_core.sv
